[rtl/rlfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlfs_pkg
// Shared types, constants and helper functions of the RC link frame sequencer.
// ----------------------------------------------------------------------------
package rlfs_pkg;

    localparam int unsigned PKT_LEN   = 18;
    localparam int unsigned HOP_LEN   = 47;
    localparam int unsigned BIND_SPAN = 5;

    localparam logic [7:0]  PKT_HDR     = 8'h11;
    localparam logic [7:0]  BIND_TAG    = 8'h03;
    localparam logic [7:0]  PKT_VER     = 8'h01;
    localparam logic [7:0]  CNT_WRAP    = 8'd188;
    localparam logic [9:0]  BIND_PKTS   = 10'd600;
    localparam logic [8:0]  HOP_MOD     = 9'h0EB;
    localparam logic [7:0]  SP_LOW      = 8'h02;
    localparam logic [7:0]  SP_HIGH     = 8'hE9;
    localparam logic [7:0]  SP_FOLD     = 8'hE7;
    localparam logic [7:0]  SP_STEP     = 8'h2F;
    localparam logic [7:0]  HOP_SKIP_A  = 8'h5A;
    localparam logic [7:0]  HOP_SKIP_B  = 8'hDC;
    localparam logic [11:0] CH_MIN      = 12'd860;
    localparam logic [11:0] CH_MAX      = 12'd2140;
    localparam logic [11:0] CH_BASE     = 12'd1226;
    localparam logic [11:0] CH_BIAS     = 12'd64;
    localparam logic [5:0]  HOP_LAST    = 6'd46;
    localparam logic [5:0]  BIND_K_LAST = 6'd45;
    localparam logic [4:0]  BYTE_LAST   = 5'd17;
    localparam logic [2:0]  FETCH_LAST  = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic       in_ready;
        logic       build_step;
        logic       accept;
        logic       fetch;
        logic [2:0] fetch_step;
        logic       load_out;
        logic [4:0] byte_idx;
    } rlfs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic build_last;
        logic bind_mode;
        logic bind_done;
        logic out_free;
    } rlfs_stat_t;

    // Hop spacing from the low id byte, with its fix-ups applied
    function automatic logic [7:0] hop_spacing(input logic [7:0] id_lo);
        logic [7:0] s;
        s = id_lo;
        if (s < SP_LOW) s = s + SP_LOW;
        if (s > SP_HIGH) s = s - SP_FOLD;
        if (s == SP_STEP || s == 8'(2 * SP_STEP) || s == 8'(3 * SP_STEP)
            || s == 8'(4 * SP_STEP))
            s = s + 8'd1;
        return s;
    endfunction

    // Step over the reserved channel numbers
    function automatic logic [7:0] hop_bump(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (v == 8'h00 || v == HOP_SKIP_A || v == HOP_SKIP_B) r = v + 8'd1;
        return r;
    endfunction

    // Clamp a pulse width and scale it to the 12-bit air format
    function automatic logic [11:0] chan_conv(input logic [11:0] raw);
        logic [11:0] v;
        logic [10:0] d;
        logic [12:0] t3;
        v = raw;
        if (v < CH_MIN) v = CH_MIN;
        if (v > CH_MAX) v = CH_MAX;
        d  = 11'(v - CH_MIN);
        t3 = {2'b00, d} + {1'b0, d, 1'b0};
        return t3[12:1] + CH_BASE + CH_BIAS;
    endfunction

endpackage

[rtl/rlfs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlfs_if
// Valid/ready channels of the frame sequencer: frame requests, packet bytes
// and the transmitter id write port.
// ----------------------------------------------------------------------------
interface rlfs_frame_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [11:0] ch0;
    logic [11:0] ch1;
    logic [11:0] ch2;
    logic [11:0] ch3;
    logic [11:0] ch4;
    logic [11:0] ch5;
    logic [11:0] ch6;
    logic [11:0] ch7;

    modport source (output valid, action, ch0, ch1, ch2, ch3, ch4, ch5, ch6, ch7,
                    input ready);
    modport sink (input valid, action, ch0, ch1, ch2, ch3, ch4, ch5, ch6, ch7,
                  output ready);
endinterface

interface rlfs_packet_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic [4:0] byte_index;
    logic [7:0] radio_channel;
    logic       is_bind;
    logic       last;

    modport source (output valid, packet_byte, byte_index, radio_channel, is_bind, last,
                    input ready);
    modport sink (input valid, packet_byte, byte_index, radio_channel, is_bind, last,
                  output ready);
endinterface

interface rlfs_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] transmitter_id;

    modport source (output valid, transmitter_id, input ready);
    modport sink (input valid, transmitter_id, output ready);
endinterface

[rtl/rc_link_frame_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_link_frame_sequencer_core
// Transmitter frame builder for a hopping RC link: hop table from the
// transmitter id, data and bind packets emitted one byte per transaction.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  --------+-----+-----------------------------------------------------------
//  frame   | in  | action (build frame / enter bind), ch0..ch7 pulse widths
//  packet  | out | packet_byte, byte_index, radio_channel, is_bind, last
//  cfg     | in  | transmitter_id write (always ready)
//
//  A packet-producing frame passes through an accept, a hop table fetch and an
//  18-byte emit; the fetch reads one entry at a time through the single
//  read port of the hop table. Bind entry and bind exit frames emit no packet.
//  After reset and after every transmitter_id write the 47-entry hop table is
//  rebuilt, one entry a cycle, with frame.ready low.
//  A stall on packet holds the current byte in the output register.
module rc_link_frame_sequencer_core
(
    input logic          clk,
    input logic          rst_n,
    rlfs_frame_if.sink   frame,
    rlfs_packet_if.source packet,
    rlfs_cfg_if.sink     cfg
);

    rlfs_pkg::rlfs_cmd_t  cmd;
    rlfs_pkg::rlfs_stat_t stat;

    logic        frame_fire;
    logic        cfg_fire;
    logic [11:0] frame_ch [8];

    assign cfg.ready   = 1'b1;
    assign frame.ready = cmd.in_ready;
    assign frame_fire  = frame.valid && frame.ready;
    assign cfg_fire    = cfg.valid && cfg.ready;

    assign frame_ch[0] = frame.ch0;
    assign frame_ch[1] = frame.ch1;
    assign frame_ch[2] = frame.ch2;
    assign frame_ch[3] = frame.ch3;
    assign frame_ch[4] = frame.ch4;
    assign frame_ch[5] = frame.ch5;
    assign frame_ch[6] = frame.ch6;
    assign frame_ch[7] = frame.ch7;

    rlfs_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_fire   (frame_fire),
        .frame_action (frame.action),
        .cfg_fire     (cfg_fire),
        .stat         (stat),
        .cmd          (cmd)
    );

    rlfs_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_fire     (cfg_fire),
        .cfg_id       (cfg.transmitter_id),
        .frame_action (frame.action),
        .frame_ch     (frame_ch),
        .out_ready    (packet.ready),
        .out_valid    (packet.valid),
        .out_byte     (packet.packet_byte),
        .out_index    (packet.byte_index),
        .out_rch      (packet.radio_channel),
        .out_bind     (packet.is_bind),
        .out_last     (packet.last)
    );

    // an id write starts a table rebuild, so no frame is taken next cycle
    a_cfg_blocks_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> !frame.ready)
        else $error("frame accepted right after transmitter id write");

    // bind packets go out on the bind channel
    a_bind_channel: assert property (@(posedge clk) disable iff (!rst_n)
        packet.valid && packet.is_bind |-> packet.radio_channel == 8'd0)
        else $error("bind packet not on bind channel");

    // data packets hop over valid, non-reserved channels only
    a_hop_channel: assert property (@(posedge clk) disable iff (!rst_n)
        packet.valid && !packet.is_bind |->
            packet.radio_channel < 8'hEB && packet.radio_channel != 8'h00
            && packet.radio_channel != rlfs_pkg::HOP_SKIP_A
            && packet.radio_channel != rlfs_pkg::HOP_SKIP_B)
        else $error("data packet on a reserved or out-of-range channel");

    // no new frame while a packet is still being emitted
    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        frame.ready |-> !(packet.valid && !packet.last && !packet.ready))
        else $error("frame accepted with a packet still in progress");

endmodule

[rtl/rlfs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlfs_ctrl
// Sequencer of the frame builder: hop table build, table fetch and byte emit.
// ----------------------------------------------------------------------------
module rlfs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frame_fire,
    input  logic                frame_action,
    input  logic                cfg_fire,
    input  rlfs_pkg::rlfs_stat_t stat,
    output rlfs_pkg::rlfs_cmd_t  cmd
);

    localparam logic [1:0] ST_BUILD = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [4:0] step_reg;
    logic [4:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BUILD;
            step_reg  <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        cmd.fetch_step = step_reg[2:0];
        cmd.byte_idx   = step_reg;
        unique case (state_reg)
            ST_BUILD:
            begin
                cmd.build_step = 1'b1;
                if (stat.build_last) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (frame_fire)
                begin
                    cmd.accept = 1'b1;
                    // a packet follows unless this is bind entry or bind exit
                    if (!frame_action && !(stat.bind_mode && stat.bind_done))
                    begin
                        state_next = ST_FETCH;
                        step_next  = 5'd0;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (step_reg[2:0] == rlfs_pkg::FETCH_LAST)
                begin
                    state_next = ST_EMIT;
                    step_next  = 5'd0;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (step_reg == rlfs_pkg::BYTE_LAST) state_next = ST_IDLE;
                    else step_next = step_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = ST_BUILD;
            end
        endcase
        // an id write restarts the table build
        if (cfg_fire) state_next = ST_BUILD;
    end

endmodule

[rtl/rlfs_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlfs_dpath
// Datapath of the frame builder: hop table memory and its generator, link
// state counters, channel conversion and the packet byte output register.
// ----------------------------------------------------------------------------
module rlfs_dpath
(
    input  logic                clk,
    input  logic                rst_n,
    input  rlfs_pkg::rlfs_cmd_t  cmd,
    output rlfs_pkg::rlfs_stat_t stat,
    input  logic                cfg_fire,
    input  logic [15:0]         cfg_id,
    input  logic                frame_action,
    input  logic [11:0]         frame_ch [8],
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic [4:0]          out_index,
    output logic [7:0]          out_rch,
    output logic                out_bind,
    output logic                out_last
);

    // link state
    logic [15:0] id_reg;
    logic [7:0]  chan_reg;
    logic [5:0]  build_idx_reg;
    logic        bind_mode_reg;
    logic [9:0]  bind_count_reg;
    logic [5:0]  bind_k_reg;
    logic [7:0]  fc_reg;
    logic [5:0]  hop_idx_reg;

    // per packet
    logic        pkt_bind_reg;
    logic [5:0]  pkt_k_reg;
    logic [11:0] conv_reg [8];
    logic [7:0]  buf_reg [5];

    // hop table memory
    logic [7:0]  hop_mem [rlfs_pkg::HOP_LEN];
    logic [7:0]  rd_data_reg;
    logic        rd_zero_reg;

    // output register
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [4:0]  out_index_reg;
    logic [7:0]  out_rch_reg;
    logic        out_bind_reg;
    logic        out_last_reg;

    logic [7:0]  spacing;
    logic [8:0]  chan_sum;
    logic [7:0]  chan_next;
    logic        build_wr;
    logic [5:0]  rd_addr;
    logic        rd_issue;
    logic        rd_in_range;
    logic [2:0]  cap_slot;
    logic [7:0]  byte_val;

    assign spacing   = rlfs_pkg::hop_spacing(id_reg[7:0]);
    assign chan_sum  = {1'b0, chan_reg} + {1'b0, spacing};
    assign chan_next = (chan_sum >= rlfs_pkg::HOP_MOD) ? 8'(chan_sum - rlfs_pkg::HOP_MOD)
                                                       : chan_sum[7:0];
    assign build_wr  = cmd.build_step && !cfg_fire;

    assign stat.build_last = (build_idx_reg == rlfs_pkg::HOP_LAST);
    assign stat.bind_mode  = bind_mode_reg;
    assign stat.bind_done  = (bind_count_reg >= rlfs_pkg::BIND_PKTS);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // table generator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg        <= 16'd0;
            chan_reg      <= 8'd0;
            build_idx_reg <= 6'd0;
        end
        else if (cfg_fire)
        begin
            id_reg        <= cfg_id;
            chan_reg      <= {5'd0, cfg_id[2:0]};
            build_idx_reg <= 6'd0;
        end
        else if (cmd.build_step)
        begin
            chan_reg      <= chan_next;
            build_idx_reg <= build_idx_reg + 6'd1;
        end
    end

    // fetch addressing: five entries from k in bind, the hop slot in data
    assign rd_addr     = pkt_bind_reg ? (pkt_k_reg + {3'd0, cmd.fetch_step}) : hop_idx_reg;
    assign rd_issue    = cmd.fetch && (cmd.fetch_step < 3'(rlfs_pkg::BIND_SPAN));
    assign rd_in_range = (rd_addr < 6'(rlfs_pkg::HOP_LEN));
    assign cap_slot    = cmd.fetch_step - 3'd1;

    always_ff @(posedge clk)
    begin
        if (build_wr) hop_mem[build_idx_reg] <= rlfs_pkg::hop_bump(chan_next);
        if (rd_issue)
        begin
            rd_zero_reg <= !rd_in_range;
            if (rd_in_range) rd_data_reg <= hop_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch && cmd.fetch_step != 3'd0)
            buf_reg[cap_slot] <= rd_zero_reg ? 8'd0 : rd_data_reg;
    end

    // link state update on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bind_mode_reg  <= 1'b0;
            bind_count_reg <= 10'd0;
            bind_k_reg     <= 6'd0;
            fc_reg         <= 8'd0;
            hop_idx_reg    <= 6'd0;
            pkt_bind_reg   <= 1'b0;
            pkt_k_reg      <= 6'd0;
        end
        else if (cmd.accept)
        begin
            priority if (frame_action)
            begin
                bind_mode_reg  <= 1'b1;
                bind_count_reg <= 10'd0;
                bind_k_reg     <= 6'd0;
            end
            else if (bind_mode_reg && stat.bind_done)
            begin
                bind_mode_reg  <= 1'b0;
                bind_count_reg <= 10'd0;
                fc_reg         <= 8'd0;
                hop_idx_reg    <= 6'd0;
            end
            else if (bind_mode_reg)
            begin
                pkt_bind_reg   <= 1'b1;
                pkt_k_reg      <= bind_k_reg;
                bind_count_reg <= bind_count_reg + 10'd1;
                bind_k_reg     <= (bind_k_reg == rlfs_pkg::BIND_K_LAST) ? 6'd0
                                  : bind_k_reg + 6'(rlfs_pkg::BIND_SPAN);
            end
            else
            begin
                pkt_bind_reg <= 1'b0;
                fc_reg       <= (fc_reg == rlfs_pkg::CNT_WRAP - 8'd1) ? 8'd0 : fc_reg + 8'd1;
                hop_idx_reg  <= (hop_idx_reg == rlfs_pkg::HOP_LAST) ? 6'd0
                                : hop_idx_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            for (int i = 0; i < 8; i++) conv_reg[i] <= rlfs_pkg::chan_conv(frame_ch[i]);
        end
    end

    // packet byte select
    always_comb
    begin
        byte_val = 8'd0;
        if (pkt_bind_reg)
        begin
            unique case (cmd.byte_idx)
                5'd0:    byte_val = rlfs_pkg::PKT_HDR;
                5'd1:    byte_val = rlfs_pkg::BIND_TAG;
                5'd2:    byte_val = rlfs_pkg::PKT_VER;
                5'd3:    byte_val = id_reg[15:8];
                5'd4:    byte_val = id_reg[7:0];
                5'd5:    byte_val = {2'd0, pkt_k_reg};
                5'd6:    byte_val = buf_reg[0];
                5'd7:    byte_val = buf_reg[1];
                5'd8:    byte_val = buf_reg[2];
                5'd9:    byte_val = buf_reg[3];
                5'd10:   byte_val = buf_reg[4];
                default: byte_val = 8'd0;
            endcase
        end
        else
        begin
            unique case (cmd.byte_idx)
                5'd0:    byte_val = rlfs_pkg::PKT_HDR;
                5'd1:    byte_val = id_reg[15:8];
                5'd2:    byte_val = id_reg[7:0];
                5'd3:    byte_val = fc_reg;
                5'd4:    byte_val = 8'd0;
                5'd5:    byte_val = rlfs_pkg::PKT_VER;
                5'd6:    byte_val = conv_reg[0][7:0];
                5'd7:    byte_val = conv_reg[1][7:0];
                5'd8:    byte_val = conv_reg[2][7:0];
                5'd9:    byte_val = conv_reg[3][7:0];
                5'd10:   byte_val = {conv_reg[1][11:8], conv_reg[0][11:8]};
                5'd11:   byte_val = {conv_reg[3][11:8], conv_reg[2][11:8]};
                5'd12:   byte_val = conv_reg[4][7:0];
                5'd13:   byte_val = conv_reg[5][7:0];
                5'd14:   byte_val = conv_reg[6][7:0];
                5'd15:   byte_val = conv_reg[7][7:0];
                5'd16:   byte_val = {conv_reg[5][11:8], conv_reg[4][11:8]};
                5'd17:   byte_val = {conv_reg[7][11:8], conv_reg[6][11:8]};
                default: byte_val = 8'd0;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (cmd.load_out) out_valid_reg <= 1'b1;
        else if (out_ready) out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_byte_reg  <= byte_val;
            out_index_reg <= cmd.byte_idx;
            out_rch_reg   <= pkt_bind_reg ? 8'd0 : buf_reg[0];
            out_bind_reg  <= pkt_bind_reg;
            out_last_reg  <= (cmd.byte_idx == rlfs_pkg::BYTE_LAST);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_index = out_index_reg;
    assign out_rch   = out_rch_reg;
    assign out_bind  = out_bind_reg;
    assign out_last  = out_last_reg;

endmodule
